@@ rtl/lisp_token_splitter_defines.svh @@
// assertion macros used by the checker file
`ifndef LISP_TOKEN_SPLITTER_DEFINES_SVH
`define LISP_TOKEN_SPLITTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define LTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lts_pkg.sv @@
// shared types, character codes and classification functions of the token splitter
package lts_pkg;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       token_first;
        logic       token_last;
    } out_item_t;

    // handshake control to the scanner: take from the input stage, drain from token_ch
    typedef struct packed {
        logic take;
        logic drain;
    } step_ctl_t;

    function automatic logic is_space(input logic [7:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

    function automatic logic ends_word(input logic [7:0] b);
        return is_space(b) || (b == CH_LPAREN) || (b == CH_RPAREN) ||
               (b == CH_HASH) || (b == CH_DQUOTE) || (b == CH_QUOTE);
    endfunction

endpackage

@@ rtl/lts_if.sv @@
// valid/ready channel carrying one payload per transfer
interface lts_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lts_scan.sv @@
// scanner: mode state, held byte and result register
module lts_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  lts_pkg::step_ctl_t ctl,
    input  lts_pkg::in_item_t item,
    output logic              take_ok,
    output logic              out_valid,
    output lts_pkg::out_item_t out_item
);
    import lts_pkg::*;

    typedef enum logic [2:0] {
        MODE_BETWEEN = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_WORD    = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_ESCAPE  = 3'd4
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic       held_first_reg, held_first_next;
    logic       lone_colon_reg, lone_colon_next;
    logic       out_valid_reg;
    out_item_t  out_item_reg;

    logic       emit;
    logic       emit_last;

    // what a byte does when it arrives between tokens
    mode_t      start_mode;
    logic       start_hold;
    logic       start_colon;

    logic [7:0] b;

    assign b = item.in_byte;

    always_comb
    begin
        start_mode  = MODE_BETWEEN;
        start_hold  = 1'b0;
        start_colon = 1'b0;
        priority if (is_space(b))
        begin
            start_hold = 1'b0;
        end
        else if (b == CH_HASH)
        begin
            start_mode = MODE_COMMENT;
        end
        else if (b == CH_DQUOTE)
        begin
            start_mode = MODE_STRING;
            start_hold = 1'b1;
        end
        else if ((b == CH_LPAREN) || (b == CH_RPAREN) || (b == CH_QUOTE))
        begin
            start_hold = 1'b1;
        end
        else
        begin
            start_mode  = MODE_WORD;
            start_hold  = 1'b1;
            start_colon = (b == CH_COLON);
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_first_next = held_first_reg;
        lone_colon_next = lone_colon_reg;
        emit            = 1'b0;
        emit_last       = 1'b0;
        if (item.end_of_stream)
        begin
            // flush, a lone colon word is dropped
            emit            = held_valid_reg && !((mode_reg == MODE_WORD) && lone_colon_reg);
            emit_last       = 1'b1;
            held_valid_next = 1'b0;
            held_first_next = 1'b0;
            lone_colon_next = 1'b0;
            mode_next       = MODE_BETWEEN;
        end
        else
        begin
            unique case (mode_reg)
                MODE_COMMENT:
                begin
                    if (b == CH_NEWLINE)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                end
                MODE_WORD:
                begin
                    if (ends_word(b))
                    begin
                        emit            = held_valid_reg && !lone_colon_reg;
                        emit_last       = 1'b1;
                        mode_next       = start_mode;
                        lone_colon_next = start_colon;
                        held_valid_next = start_hold;
                        held_first_next = start_hold;
                        if (start_hold)
                        begin
                            held_byte_next = b;
                        end
                    end
                    else
                    begin
                        emit            = held_valid_reg;
                        emit_last       = 1'b0;
                        lone_colon_next = 1'b0;
                        held_byte_next  = b;
                        held_valid_next = 1'b1;
                        held_first_next = 1'b0;
                    end
                end
                MODE_STRING, MODE_ESCAPE:
                begin
                    emit            = held_valid_reg;
                    emit_last       = 1'b0;
                    held_byte_next  = b;
                    held_valid_next = 1'b1;
                    held_first_next = 1'b0;
                    priority if (mode_reg == MODE_ESCAPE)
                    begin
                        mode_next = MODE_STRING;
                    end
                    else if (b == CH_BSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (b == CH_DQUOTE)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else
                    begin
                        mode_next = MODE_STRING;
                    end
                end
                default:
                begin
                    emit            = held_valid_reg;
                    emit_last       = 1'b1;
                    mode_next       = start_mode;
                    lone_colon_next = start_colon;
                    held_valid_next = start_hold;
                    held_first_next = start_hold;
                    if (start_hold)
                    begin
                        held_byte_next = b;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_BETWEEN;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_first_reg <= 1'b0;
            lone_colon_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else if (ctl.take)
        begin
            mode_reg       <= mode_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_first_reg <= held_first_next;
            lone_colon_reg <= lone_colon_next;
            out_valid_reg  <= emit;
            out_item_reg   <= '{out_byte: held_byte_reg, token_first: held_first_reg,
                                token_last: emit_last};
        end
        else if (ctl.drain)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign take_ok   = !out_valid_reg || ctl.drain;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ rtl/lisp_token_splitter.sv @@
// top level of the lisp token splitter
//
//  channel    dir   payload                                  role
//  char_ch    sink  in_byte[7:0], end_of_stream              source bytes / stream end
//  token_ch   src   out_byte[7:0], token_first, token_last   token bytes with marks
//
// one byte per cycle sustained while token_ch is ready; a byte reaches token_ch via
// the input and result registers after its successor (or the end-of-stream item) is
// transferred in, as each token byte is held until the next decides its last mark
// reset leaves the scanner between tokens with nothing held
// a stall on token_ch backs up into one input register, then drops char_ch ready
module lisp_token_splitter (
    input logic clk,
    input logic rst_n,
    lts_if.sink char_ch,
    lts_if.source token_ch
);
    import lts_pkg::*;

    // input register stage
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_item_reg;
    logic      take_ok;
    logic      advance;
    step_ctl_t ctl;

    // the scanner takes the registered item when its result register frees up
    assign advance       = in_valid_reg && take_ok;
    assign char_ch.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (char_ch.valid && char_ch.ready)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // payload register, loaded on every input transfer
    always_ff @(posedge clk)
    begin
        if (char_ch.valid && char_ch.ready)
        begin
            in_item_reg <= char_ch.payload;
        end
    end

    assign ctl.take  = advance;
    assign ctl.drain = token_ch.ready;

    // mode logic, held byte and result register
    lts_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .item      (in_item_reg),
        .take_ok   (take_ok),
        .out_valid (token_ch.valid),
        .out_item  (token_ch.payload)
    );

endmodule

@@ rtl/lts_checker.sv @@
// port-level checks on the token splitter and their bind
`include "lisp_token_splitter_defines.svh"

module lts_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input lts_pkg::out_item_t out_payload
);
    import lts_pkg::*;

    logic xfer;
    logic open_tok_reg;

    assign xfer = out_valid && out_ready;

    // a token has started and its last byte is still to come
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_tok_reg <= 1'b0;
        end
        else if (xfer)
        begin
            open_tok_reg <= !out_payload.token_last;
        end
    end

    `LTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload), "token transfer changed while stalled")
    `LTS_ASSERT_NOW(a_first_opens, xfer && !open_tok_reg, out_payload.token_first, "token byte outside a token lacks first mark")
    `LTS_ASSERT_NOW(a_no_reopen, xfer && open_tok_reg, !out_payload.token_first, "new token began before last mark")
    `LTS_ASSERT_NOW(a_single_byte, xfer && out_payload.token_first && out_payload.token_last, (out_payload.out_byte != CH_COLON) && !is_space(out_payload.out_byte), "lone colon or whitespace emitted as token")

endmodule

bind lisp_token_splitter lts_checker u_lts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (token_ch.valid),
    .out_ready   (token_ch.ready),
    .out_payload (token_ch.payload)
);
